// File: design/overwriting_byte_ring_buffer_top_defines.svh
// assertion macros for the overwriting byte ring buffer
// used by overwriting_byte_ring_buffer_top.sv, depends on nothing
`ifndef OVERWRITING_BYTE_RING_BUFFER_TOP_DEFINES_SVH
`define OVERWRITING_BYTE_RING_BUFFER_TOP_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define OBRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring buffer check failed in the same cycle");

// consequent holds in the cycle after the antecedent
`define OBRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring buffer check failed one cycle later");

`endif

// File: design/obrb_pkg.sv
// shared types and constants of the overwriting byte ring buffer
// no dependencies; used by obrb_ctrl and the top level
package obrb_pkg;

   localparam int OP_W     = 3;
   localparam int DATA_W   = 8;
   localparam int OFFSET_W = 10;
   localparam int COUNT_W  = 11;
   localparam int USED_W   = 11;

   // ring depth, a power of two that the offset, count and used fields can cover
   localparam int DEPTH    = 1024;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_PEEK  = 3'd2,
      OP_DROP  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   // result fields that do not come from the byte store
   typedef struct packed {
      logic              has_data;
      logic              status;
      logic [USED_W-1:0] used_count;
      logic              is_full;
      logic              is_empty;
      logic              overwrote;
   } rsp_meta_type;

endpackage

// File: design/overwriting_byte_ring_buffer_top.sv
// top level of the overwriting byte ring buffer
// depends on obrb_pkg, obrb_ctrl, obrb_ram and overwriting_byte_ring_buffer_top_defines.svh
//
//   channel   direction   handshake              payload
//   req       in          req_tvalid/req_tready  operation, write_data, peek_offset, drop_count
//   rsp       out         rsp_tvalid/rsp_tready  read_data, status, used_count, flags
//
// one request per cycle while the response is taken, every request gives exactly one response in the next cycle
// the byte store is a ram with a registered read; its read register holds the
// read data, so a read never has to be reissued while the response stalls
// a write is visible to any read issued after it, so no forwarding is needed
// reset clears indices and count; the store itself is left as is, no clearing pass
// a stalled response blocks new requests only while it is not taken
`include "overwriting_byte_ring_buffer_top_defines.svh"

module overwriting_byte_ring_buffer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0], write_data[10:3], peek_offset[20:11], drop_count[31:21]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], status[8], used_count[19:9], is_full[20], is_empty[21],
   // overwrote[22], zero[23]
   output logic [23:0] rsp_tdata
);

   localparam int AW = $clog2(obrb_pkg::DEPTH);

   logic                           req_accept;
   obrb_pkg::op_type               req_op;
   logic                           mem_wr_en;
   logic [AW-1:0]                  mem_wr_addr;
   logic [obrb_pkg::DATA_W-1:0]    mem_wr_data;
   logic                           mem_rd_en;
   logic [AW-1:0]                  mem_rd_addr;
   logic [obrb_pkg::DATA_W-1:0]    mem_rd_data;
   obrb_pkg::rsp_meta_type         meta;

   // response stage
   logic                           rsp_valid_ff, rsp_valid_in;
   obrb_pkg::rsp_meta_type         meta_ff;
   logic [obrb_pkg::DATA_W-1:0]    rsp_read_data;

   // the stage frees up when its response is taken in the same cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = obrb_pkg::op_type'(req_tdata[2:0]);

   obrb_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .req_op          (req_op),
      .req_write_data  (req_tdata[10:3]),
      .req_peek_offset (req_tdata[20:11]),
      .req_drop_count  (req_tdata[31:21]),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .meta            (meta)
   );

   // read data holds because a read is issued only with an accepted request
   obrb_ram #(
      .WIDTH(obrb_pkg::DATA_W),
      .DEPTH(obrb_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         meta_ff <= meta;
      end
   end

   // failed or non-reading operations answer with a zero byte
   assign rsp_read_data = meta_ff.has_data ? mem_rd_data : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, meta_ff.overwrote, meta_ff.is_empty, meta_ff.is_full,
                        meta_ff.used_count, meta_ff.status, rsp_read_data};

   // an accepted request always shows up as a response in the next cycle
   `OBRB_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid_ff)
   // only a write into a full buffer overwrites, and it stays full
   `OBRB_ASSERT_NOW(a_overwrite_full, clock, reset,
      rsp_valid_ff && meta_ff.overwrote, meta_ff.is_full && !meta_ff.is_empty)
   // a refused operation never carries store data
   `OBRB_ASSERT_NOW(a_refused_no_data, clock, reset,
      rsp_valid_ff && meta_ff.status, !meta_ff.has_data && !meta_ff.overwrote)

endmodule

// File: design/obrb_ram.sv
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
module obrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/obrb_ctrl.sv
// index and count keeping of the ring buffer, issues store accesses
// depends on obrb_pkg
module obrb_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_accept,
   input  obrb_pkg::op_type                     req_op,
   input  logic [obrb_pkg::DATA_W-1:0]          req_write_data,
   input  logic [obrb_pkg::OFFSET_W-1:0]        req_peek_offset,
   input  logic [obrb_pkg::COUNT_W-1:0]         req_drop_count,
   output logic                                 mem_wr_en,
   output logic [$clog2(obrb_pkg::DEPTH)-1:0]   mem_wr_addr,
   output logic [obrb_pkg::DATA_W-1:0]          mem_wr_data,
   output logic                                 mem_rd_en,
   output logic [$clog2(obrb_pkg::DEPTH)-1:0]   mem_rd_addr,
   output obrb_pkg::rsp_meta_type               meta
);

   localparam int AW = $clog2(obrb_pkg::DEPTH);
   localparam int CW = AW + 1;
   // wide enough for any index, count or request field
   localparam int SW = ((CW > obrb_pkg::COUNT_W) ? CW : obrb_pkg::COUNT_W) + 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(obrb_pkg::DEPTH);

   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] held_ff, held_in;

   logic [SW-1:0] held_ext;
   logic [SW-1:0] offset_ext;
   logic [SW-1:0] count_ext;
   logic [SW-1:0] peek_sum;
   logic [SW-1:0] drop_sum;
   logic [SW-1:0] used_ext;

   assign held_ext   = SW'(held_ff);
   assign offset_ext = SW'(req_peek_offset);
   assign count_ext  = SW'(req_drop_count);
   assign peek_sum   = SW'(rd_idx_ff) + offset_ext;
   assign drop_sum   = SW'(rd_idx_ff) + count_ext;
   assign used_ext   = SW'(held_in);

   assign mem_wr_addr = wr_idx_ff;
   assign mem_wr_data = req_write_data;

   always_comb begin
      wr_idx_in      = wr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      held_in        = held_ff;
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = rd_idx_ff;
      meta.has_data  = 1'b0;
      meta.status    = 1'b0;
      meta.overwrote = 1'b0;
      case (req_op)
         obrb_pkg::OP_WRITE: begin
            mem_wr_en = req_accept;
            wr_idx_in = wr_idx_ff + AW'(1);
            if (held_ff == FULL_COUNT) begin
               // full: the oldest byte goes
               rd_idx_in      = rd_idx_ff + AW'(1);
               meta.overwrote = 1'b1;
            end else begin
               held_in = held_ff + CW'(1);
            end
         end
         obrb_pkg::OP_READ: begin
            if (held_ff == '0) begin
               meta.status = 1'b1;
            end else begin
               mem_rd_en     = req_accept;
               meta.has_data = 1'b1;
               rd_idx_in     = rd_idx_ff + AW'(1);
               held_in       = held_ff - CW'(1);
            end
         end
         obrb_pkg::OP_PEEK: begin
            if (offset_ext >= held_ext) begin
               meta.status = 1'b1;
            end else begin
               mem_rd_en     = req_accept;
               mem_rd_addr   = peek_sum[AW-1:0];
               meta.has_data = 1'b1;
            end
         end
         obrb_pkg::OP_DROP: begin
            if (count_ext > held_ext) begin
               meta.status = 1'b1;
            end else begin
               // count never exceeds depth here, so the low bits wrap correctly
               rd_idx_in = drop_sum[AW-1:0];
               held_in   = held_ff - count_ext[CW-1:0];
            end
         end
         obrb_pkg::OP_CLEAR: begin
            // only held entries are ever read, so the store needs no wipe
            wr_idx_in = '0;
            rd_idx_in = '0;
            held_in   = '0;
         end
         default: begin
         end
      endcase
      meta.used_count = used_ext[obrb_pkg::USED_W-1:0];
      meta.is_full    = (held_in == FULL_COUNT);
      meta.is_empty   = (held_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         held_ff   <= '0;
      end else if (req_accept) begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         held_ff   <= held_in;
      end
   end

endmodule

// File: tb/tb_overwriting_byte_ring_buffer_top.sv
// self-checking testbench for overwriting_byte_ring_buffer_top
// depends on obrb_pkg and the ring buffer rtl; a shadow ring predicts every response
`timescale 1ns / 100ps

module tb_overwriting_byte_ring_buffer_top;

   localparam int RING_DEPTH  = obrb_pkg::DEPTH;
   localparam int HALF_PERIOD = 6;
   localparam int HOLD_CYCLES = 80;
   localparam int MAX_REPORTS = 10;

   // one response as it appears on rsp_tdata, highest bits first
   typedef struct packed {
      logic        overwrote;
      logic        is_empty;
      logic        is_full;
      logic [10:0] used_count;
      logic        status;
      logic [7:0]  read_data;
   } ring_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // operation[2:0], write_data[10:3], peek_offset[20:11], drop_count[31:21]
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // read_data[7:0], status[8], used_count[19:9], is_full[20], is_empty[21],
   // overwrote[22], zero[23]
   logic [23:0] rsp_tdata;

   // shadow copy of the ring contents and pointers
   logic [7:0]  shadow_store [RING_DEPTH];
   logic [9:0]  shadow_wr_ptr;
   logic [9:0]  shadow_rd_ptr;
   logic [10:0] shadow_fill;

   // responses predicted but not yet seen, oldest first
   ring_rsp_type pending_rsp_q[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_pending  = 1'b0;
   int unsigned error_count   = 0;

   overwriting_byte_ring_buffer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // shadow ring: applies one accepted request and returns its response
   // ------------------------------------------------------------------
   task automatic apply_ring_op(input obrb_pkg::op_type op, input logic [7:0] wdata,
                                input logic [9:0] offset, input logic [10:0] count,
                                output ring_rsp_type rsp);
      logic [9:0] peek_slot;
      rsp = '0;
      case (op)
         obrb_pkg::OP_WRITE: begin
            shadow_store[shadow_wr_ptr] = wdata;
            shadow_wr_ptr = shadow_wr_ptr + 10'd1;
            // full ring: oldest byte is pushed out, count stays at depth
            if (shadow_fill == RING_DEPTH) begin
               shadow_rd_ptr = shadow_rd_ptr + 10'd1;
               rsp.overwrote = 1'b1;
            end else begin
               shadow_fill = shadow_fill + 11'd1;
            end
         end
         obrb_pkg::OP_READ: begin
            if (shadow_fill == 0) begin
               rsp.status = 1'b1;
            end else begin
               rsp.read_data = shadow_store[shadow_rd_ptr];
               shadow_rd_ptr = shadow_rd_ptr + 10'd1;
               shadow_fill = shadow_fill - 11'd1;
            end
         end
         obrb_pkg::OP_PEEK: begin
            if ({1'b0, offset} >= shadow_fill) begin
               rsp.status = 1'b1;
            end else begin
               peek_slot = shadow_rd_ptr + offset;
               rsp.read_data = shadow_store[peek_slot];
            end
         end
         obrb_pkg::OP_DROP: begin
            if (count > shadow_fill) begin
               rsp.status = 1'b1;
            end else begin
               // a drop of the whole depth leaves the read pointer where it was
               shadow_rd_ptr = shadow_rd_ptr + count[9:0];
               shadow_fill = shadow_fill - count;
            end
         end
         obrb_pkg::OP_CLEAR: begin
            foreach (shadow_store[i]) shadow_store[i] = 8'h00;
            shadow_wr_ptr = '0;
            shadow_rd_ptr = '0;
            shadow_fill = '0;
         end
         default: ;
      endcase
      rsp.used_count = shadow_fill;
      rsp.is_full    = (shadow_fill == RING_DEPTH);
      rsp.is_empty   = (shadow_fill == 0);
   endtask

   // ------------------------------------------------------------------
   // request driver: random gaps, then hold the request until accepted
   // ------------------------------------------------------------------
   task automatic send_ring_op(input obrb_pkg::op_type op, input logic [7:0] wdata,
                               input logic [9:0] offset, input logic [10:0] count);
      ring_rsp_type predicted;
      // idle cycles carry junk payload with valid low
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {count, offset, wdata, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge, predict in acceptance order
      apply_ring_op(op, wdata, offset, count, predicted);
      pending_rsp_q.push_back(predicted);
   endtask

   // ------------------------------------------------------------------
   // response side: random ready, or a long counted hold-off on request
   // ------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // response checker: every accepted response against the oldest prediction
   always @(posedge clock) begin
      ring_rsp_type got;
      ring_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[22:0];
         if (pending_rsp_q.size() == 0) begin
            log_error($sformatf("unexpected response %h", rsp_tdata));
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.read_data !== want.read_data || got.status !== want.status ||
                got.used_count !== want.used_count || got.is_full !== want.is_full ||
                got.is_empty !== want.is_empty || got.overwrote !== want.overwrote) begin
               log_error($sformatf({"data exp %h got %h, status exp %b got %b, ",
                  "used exp %0d got %0d, full exp %b got %b, empty exp %b got %b, ",
                  "overwrote exp %b got %b"},
                  want.read_data, got.read_data, want.status, got.status,
                  want.used_count, got.used_count, want.is_full, got.is_full,
                  want.is_empty, got.is_empty, want.overwrote, got.overwrote));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // empty-ring errors, byte extremes, peek and drop bounds, clear
   task automatic test_directed_corners();
      send_ring_op(obrb_pkg::OP_READ,  8'h00, 10'd0,    11'd0);    // read when empty
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'd0,    11'd0);    // peek with nothing held
      send_ring_op(obrb_pkg::OP_PEEK,  8'hFF, 10'd1023, 11'd0);
      send_ring_op(obrb_pkg::OP_DROP,  8'h00, 10'd0,    11'd0);    // zero drop always succeeds
      send_ring_op(obrb_pkg::OP_DROP,  8'h00, 10'd0,    11'd1);    // drop more than held
      send_ring_op(obrb_pkg::OP_DROP,  8'h00, 10'd1023, 11'd1024);
      send_ring_op(obrb_pkg::OP_WRITE, 8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_WRITE, 8'hFF, 10'd1023, 11'd1024);
      send_ring_op(obrb_pkg::OP_WRITE, 8'h5A, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'd2,    11'd0);
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'd3,    11'd0);    // just past the newest byte
      send_ring_op(obrb_pkg::OP_DROP,  8'h00, 10'd0,    11'd4);
      send_ring_op(obrb_pkg::OP_READ,  8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_DROP,  8'h00, 10'd0,    11'd1);
      send_ring_op(obrb_pkg::OP_READ,  8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_READ,  8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_WRITE, 8'hA5, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_CLEAR, 8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_READ,  8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'd0,    11'd0);
   endtask

   // fill past depth so writes overwrite, then peek and drop at the limits
   task automatic test_full_wraparound();
      send_ring_op(obrb_pkg::OP_CLEAR, 8'h00, 10'd0, 11'd0);
      repeat (RING_DEPTH + 6)
         send_ring_op(obrb_pkg::OP_WRITE, 8'($urandom()), 10'($urandom()), 11'd0);
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'd1023, 11'd0);
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'($urandom()), 11'd0);
      send_ring_op(obrb_pkg::OP_READ,  8'h00, 10'd0,    11'd0);
      send_ring_op(obrb_pkg::OP_PEEK,  8'h00, 10'd1023, 11'd0);    // one short of full now
      send_ring_op(obrb_pkg::OP_WRITE, 8'($urandom()), 10'd0, 11'd0);  // refills, no overwrite
      send_ring_op(obrb_pkg::OP_DROP,  8'h00, 10'd0, 11'd1024);    // whole ring at once
      send_ring_op(obrb_pkg::OP_READ,  8'h00, 10'd0, 11'd0);
      repeat (4) send_ring_op(obrb_pkg::OP_WRITE, 8'($urandom()), 10'd0, 11'd0);
      repeat (4) send_ring_op(obrb_pkg::OP_READ, 8'h00, 10'd0, 11'd0);
   endtask

   // response side held off while requests keep coming, input must stall
   task automatic test_backpressure_fill();
      send_idle_pct = 0;
      hold_pending  = 1'b1;
      repeat (30)
         send_ring_op(obrb_pkg::OP_WRITE, 8'($urandom()), 10'($urandom()), 11'd0);
      repeat (30)
         send_ring_op(obrb_pkg::OP_READ, 8'($urandom()), 10'($urandom()), 11'd0);
   endtask

   // mostly legal operations with random content, some out-of-range ones
   task automatic test_random_traffic(input int unsigned send_pct,
                                      input int unsigned recv_pct,
                                      input int unsigned n_reqs);
      int unsigned pick;
      logic [7:0]  wdata;
      logic [9:0]  offset;
      logic [10:0] count;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (n_reqs) begin
         pick   = $urandom_range(99);
         wdata  = 8'($urandom());
         offset = 10'($urandom());
         count  = 11'($urandom_range(RING_DEPTH));
         if (pick < 45) begin
            send_ring_op(obrb_pkg::OP_WRITE, wdata, offset, count);
         end else if (pick < 64) begin
            send_ring_op(obrb_pkg::OP_READ, wdata, offset, count);
         end else if (pick < 82) begin
            // in-range peek most of the time, anywhere otherwise
            if (shadow_fill != 0 && $urandom_range(99) < 85)
               offset = 10'($urandom_range(int'(shadow_fill) - 1));
            send_ring_op(obrb_pkg::OP_PEEK, wdata, offset, count);
         end else if (pick < 98) begin
            if ($urandom_range(99) < 85)
               count = 11'($urandom_range((shadow_fill < 16) ? int'(shadow_fill) : 16));
            send_ring_op(obrb_pkg::OP_DROP, wdata, offset, count);
         end else begin
            send_ring_op(obrb_pkg::OP_CLEAR, wdata, offset, count);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // shadow pointers start where reset leaves the rtl; store unknown until written
      shadow_wr_ptr = '0;
      shadow_rd_ptr = '0;
      shadow_fill   = '0;
      @(posedge clock);

      send_idle_pct = 38;
      recv_idle_pct = 70;
      test_directed_corners();
      test_full_wraparound();
      test_random_traffic(38, 70, 75);
      test_backpressure_fill();
      test_random_traffic(70, 38, 75);
      test_random_traffic(0, 0, 75);

      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
